FILE: hdl/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [6:0] SYM_SKIP = 7'd64;
    localparam logic [6:0] SYM_BAD  = 7'd65;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_PADDING = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    localparam logic [2:0] MIN_CHARS = 3'd4;

    typedef enum logic [2:0] {
        SCAN_DATA  = 3'b001,
        SCAN_CHECK = 3'b010,
        SCAN_DONE  = 3'b100
    } t_scan;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] decoded_count;
    } t_out_item;

    function automatic logic [6:0] sym_of(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 7'd62;
        end else if (c == 8'h2F) begin
            s = 7'd63;
        end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20) begin
            s = SYM_SKIP;
        end else begin
            s = SYM_BAD;
        end
        return s;
    endfunction

endpackage

FILE: hdl/b64d_step.sv
module b64d_step
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic [1:0]             r_phase, n_phase;
    logic [5:0]             r_partial, n_partial;
    t_scan                  r_mode, n_mode;
    logic [1:0]             r_pad_phase, n_pad_phase;
    logic [1:0]             r_err, n_err;
    logic [2:0]             r_ccount, n_ccount;
    logic [COUNT_WIDTH-1:0] r_bcount, n_bcount;

    logic [6:0]              w_sym;
    logic                    w_is_pad;
    logic                    w_have_byte;
    logic [7:0]              w_byte;
    logic [1:0]              w_err_end;
    logic [COUNT_WIDTH+15:0] w_count_ext;

    assign w_sym       = sym_of(i_item.char_code);
    assign w_is_pad    = (i_item.char_code == PAD_CHAR);
    assign w_count_ext = {16'd0, n_bcount};

    always_comb begin
        n_phase     = r_phase;
        n_partial   = r_partial;
        n_mode      = r_mode;
        n_pad_phase = r_pad_phase;
        n_err       = r_err;
        n_ccount    = (r_ccount < MIN_CHARS) ? r_ccount + 3'd1 : r_ccount;
        w_have_byte = 1'b0;
        w_byte      = 8'd0;

        if (r_err == ST_OK) begin
            unique case (r_mode)
                SCAN_DATA: begin
                    if (w_is_pad) begin
                        if (r_phase < 2'd2) begin
                            n_err = ST_PADDING;
                        end else begin
                            n_pad_phase = r_phase;
                            n_mode      = SCAN_CHECK;
                        end
                    end else if (w_sym == SYM_BAD) begin
                        n_err = ST_INVALID;
                    end else if (w_sym != SYM_SKIP) begin
                        case (r_phase)
                            2'd0: begin
                                n_partial = w_sym[5:0];
                            end
                            2'd1: begin
                                w_byte      = {r_partial, w_sym[5:4]};
                                n_partial   = {2'b00, w_sym[3:0]};
                                w_have_byte = 1'b1;
                            end
                            2'd2: begin
                                w_byte      = {r_partial[3:0], w_sym[5:2]};
                                n_partial   = {4'b0000, w_sym[1:0]};
                                w_have_byte = 1'b1;
                            end
                            default: begin
                                w_byte      = {r_partial[1:0], w_sym[5:0]};
                                n_partial   = 6'd0;
                                w_have_byte = 1'b1;
                            end
                        endcase
                        n_phase = r_phase + 2'd1;
                    end
                end
                SCAN_CHECK: begin
                    if (w_sym != SYM_SKIP) begin
                        if (r_pad_phase == 2'd2 && !w_is_pad) n_err = ST_PADDING;
                        if (r_pad_phase == 2'd3 && w_is_pad) n_err = ST_PADDING;
                        n_mode = SCAN_DONE;
                    end
                end
                SCAN_DONE: begin
                end
                default: begin
                    n_mode = SCAN_DATA;
                end
            endcase
        end

        n_bcount = (w_have_byte && r_bcount != {COUNT_WIDTH{1'b1}}) ?
                   r_bcount + COUNT_WIDTH'(1) : r_bcount;

        w_err_end = n_err;
        if (n_err == ST_OK) begin
            if (n_mode == SCAN_DATA && n_phase != 2'd0) w_err_end = ST_PADDING;
            if (n_mode == SCAN_CHECK && n_pad_phase == 2'd2) w_err_end = ST_PADDING;
        end

        o_res_valid              = w_have_byte || i_item.last_char;
        o_res.data_byte          = w_byte;
        o_res.byte_valid         = w_have_byte;
        o_res.done_res           = i_item.last_char;
        o_res.status             = ST_OK;
        o_res.decoded_count      = 16'd0;
        if (i_item.last_char) begin
            o_res.status        = (n_ccount < MIN_CHARS) ? ST_SHORT : w_err_end;
            o_res.decoded_count = w_count_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_char)) begin
            r_phase     <= 2'd0;
            r_partial   <= 6'd0;
            r_mode      <= SCAN_DATA;
            r_pad_phase <= 2'd0;
            r_err       <= ST_OK;
            r_ccount    <= 3'd0;
            r_bcount    <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_partial   <= n_partial;
            r_mode      <= n_mode;
            r_pad_phase <= n_pad_phase;
            r_err       <= n_err;
            r_ccount    <= n_ccount;
            r_bcount    <= n_bcount;
        end
    end

endmodule

FILE: hdl/b64d_out_buf.sv
module b64d_out_buf
    import b64d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_push_item,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;
    logic      w_load;

    assign w_load  = (r_main_valid && !i_stall) || !r_main_valid;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_push_item;
            end else begin
                r_main <= i_push_item;
            end
        end else if (i_push) begin
            r_skid <= i_push_item;
        end
    end

endmodule

FILE: hdl/base64_stream_decoder.sv
// An accepted character waits in the input register; its result, if it yields one,
// goes to the output register, or to the skid register while the output is stalled.
// One character per cycle unless the skid is full; set by the single-pass decode step.
// Reset (i_rst_n low, synchronous) empties all three registers and returns the
// string state to its start; the state also returns to start after each last character.
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      w_full;
    logic      w_advance;
    logic      w_in_accept;
    logic      w_res_valid;
    t_out_item w_res;

    assign o_in_stall  = r_in_valid && w_full;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_advance   = r_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    b64d_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_item     (r_in_item),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    b64d_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_advance && w_res_valid),
        .i_push_item(w_res),
        .o_full     (w_full),
        .o_valid    (o_out_valid),
        .o_item     (o_out_item),
        .i_stall    (i_out_stall)
    );

    a_in_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_full && !w_in_accept) |=> !r_in_valid)
        else $error("input register held without a stall");

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.byte_valid || o_out_item.done_res))
        else $error("result carries neither byte nor status");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.done_res) |->
        (o_out_item.status == ST_OK && o_out_item.decoded_count == 16'd0))
        else $error("status or count outside the final result");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.byte_valid) |-> (o_out_item.data_byte == 8'd0))
        else $error("data byte set without a decoded byte");

endmodule
